>>> rtl/vpa_pkg.sv
// Shared types, codes and defaults of the variable partition allocator.
`default_nettype none
package vpa_pkg;

	localparam int DEF_MAX_PARTS = 64;
	localparam int DEF_UNIT_BITS = 16;
	localparam logic [15:0] RESET_UNITS = 16'd100;

	localparam logic [2:0] ACT_FIRST  = 3'd0;
	localparam logic [2:0] ACT_BEST   = 3'd1;
	localparam logic [2:0] ACT_WORST  = 3'd2;
	localparam logic [2:0] ACT_FREE   = 3'd3;
	localparam logic [2:0] ACT_DEFRAG = 3'd4;

	localparam logic [2:0] STS_OK        = 3'd0;
	localparam logic [2:0] STS_NO_FIT    = 3'd1;
	localparam logic [2:0] STS_FULL      = 3'd2;
	localparam logic [2:0] STS_NOT_FOUND = 3'd3;
	localparam logic [2:0] STS_ZERO      = 3'd4;

	typedef enum logic [4:0] {
		ST_INIT,
		ST_IDLE,
		ST_LOOP,
		ST_RD,
		ST_SCAN,
		ST_ALLOC_END,
		ST_UP,
		ST_UP_WR,
		ST_INS_WR,
		ST_PICK_WR,
		ST_F_FOUND,
		ST_F_NEXT,
		ST_DN,
		ST_DN_WR,
		ST_F_PREV,
		ST_F_PCHK,
		ST_F_WR,
		ST_DEF_END,
		ST_DEF_INS,
		ST_DONE
	} vpa_state_t;

endpackage
`default_nettype wire

>>> rtl/variable_partition_allocator_top.sv
// Partition table allocator: first, best and worst fit, free with merge, defragment.
//
//  channel | direction | handshake            | payload
//  in      | into      | in_valid / in_stall   | action, request_size, free_offset
//  out     | out of    | out_valid / out_stall | status, result_offset, allocated_units
//  cfg     | into      | cfg_valid / cfg_ready | cfg_data (memory_units)
//
// Each table entry scanned passes through a step, a memory read and its use; each entry moved
// for a split or a merge takes a read and a write. The time per item is set by the single-port
// table memory and the sequencer that walks it; a zero-size allocation or an unknown action
// goes straight to the result, and no new item is taken until the current one is done.
// After reset, and after each cfg write, the INIT state loads the single free partition.
// A finished result waits in the output register; the next item may be taken meanwhile.
`default_nettype none
module variable_partition_allocator_top import vpa_pkg::*; #(
	parameter int MAX_PARTS = DEF_MAX_PARTS,
	parameter int UNIT_BITS = DEF_UNIT_BITS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  action,
	input  wire logic [15:0] request_size,
	input  wire logic [15:0] free_offset,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       status,
	output logic [15:0]      result_offset,
	output logic [15:0]      allocated_units,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data
);

	localparam int SW = UNIT_BITS;
	localparam int OW = (UNIT_BITS > 16) ? UNIT_BITS : 16;
	localparam int CW = $clog2(MAX_PARTS + 1);
	localparam int IW = $clog2(MAX_PARTS);
	localparam logic [SW-1:0] UMAX = '1;

	vpa_state_t state_q, state_d;

	logic [SW:0]   tab_mem [MAX_PARTS];
	logic [SW:0]   rd_q;
	logic [IW-1:0] rd_addr, wr_addr;
	logic          wr_en;
	logic [SW:0]   wr_data;

	logic [2:0]    op_q, st_q;
	logic [15:0]   req_q, tgt_q, mem_units_q, alloc_q;
	logic [CW-1:0] idx_q, pick_q, kept_q, j_q, stop_q, cnt_q;
	logic [SW-1:0] off_q, pick_off_q, pick_size_q, best_q, cur_size_q, sum_q;
	logic          found_q, cur_used_q, phase_q, out_valid_q;
	logic [2:0]    status_q;
	logic [15:0]   result_offset_q, allocated_units_q;

	logic          rd_used, fits, exact, better, off_match, is_alloc, in_acc, out_go;
	logic [SW-1:0] rd_size, diff, cap_units;
	logic [CW-1:0] idx_p1, idx_m1, j_p1, j_m1;

	assign rd_used  = rd_q[SW];
	assign rd_size  = rd_q[SW-1:0];
	assign is_alloc = (op_q inside {ACT_FIRST, ACT_BEST, ACT_WORST});
	assign fits     = !rd_used && (OW'(rd_size) >= OW'(req_q));
	assign exact    = OW'(rd_size) == OW'(req_q);
	assign diff     = rd_size - SW'(req_q);
	assign off_match = OW'(off_q) == OW'(tgt_q);
	assign idx_p1   = idx_q + CW'(1);
	assign idx_m1   = idx_q - CW'(1);
	assign j_p1     = j_q + CW'(1);
	assign j_m1     = j_q - CW'(1);
	assign cap_units = (OW'(mem_units_q) > OW'(UMAX)) ? UMAX : SW'(mem_units_q);

	always_comb begin
		case (op_q)
			ACT_FIRST: better = 1'b1;
			ACT_BEST:  better = exact || !found_q || (diff < best_q);
			ACT_WORST: better = !found_q || (rd_size > pick_size_q);
			default:   better = 1'b0;
		endcase
	end

	assign cfg_ready = (state_q == ST_IDLE) && !out_valid_q;
	// hold the input off while a cfg write is taken
	assign in_stall  = (state_q != ST_IDLE) || (cfg_valid && cfg_ready);
	assign in_acc    = in_valid && !in_stall;
	assign out_go    = !out_valid_q || !out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: state_d = ST_IDLE;
			ST_IDLE: begin
				if (cfg_valid && cfg_ready)
					state_d = ST_INIT;
				else if (in_acc) begin
					if ((action inside {ACT_FIRST, ACT_BEST, ACT_WORST}) && request_size == '0)
						state_d = ST_DONE;
					else if (action > ACT_DEFRAG)
						state_d = ST_DONE;
					else
						state_d = ST_LOOP;
				end
			end
			ST_LOOP: begin
				if (idx_q < cnt_q)
					state_d = ST_RD;
				else if (is_alloc)
					state_d = ST_ALLOC_END;
				else if (op_q == ACT_FREE)
					state_d = ST_DONE;
				else
					state_d = ST_DEF_END;
			end
			ST_RD: state_d = ST_SCAN;
			ST_SCAN: begin
				if (is_alloc)
					state_d = (fits && (op_q == ACT_FIRST || (op_q == ACT_BEST && exact)))
						? ST_ALLOC_END : ST_LOOP;
				else if (op_q == ACT_FREE)
					state_d = off_match ? ST_F_FOUND : ST_LOOP;
				else
					state_d = ST_LOOP;
			end
			ST_ALLOC_END: begin
				if (!found_q)
					state_d = ST_DONE;
				else if (OW'(pick_size_q) > OW'(req_q))
					state_d = (cnt_q == CW'(MAX_PARTS)) ? ST_DONE : ST_UP;
				else
					state_d = ST_PICK_WR;
			end
			ST_UP: begin
				if (j_q > stop_q)
					state_d = ST_UP_WR;
				else
					state_d = (op_q == ACT_DEFRAG) ? ST_DEF_INS : ST_INS_WR;
			end
			ST_UP_WR:   state_d = ST_UP;
			ST_INS_WR:  state_d = ST_PICK_WR;
			ST_PICK_WR: state_d = ST_DONE;
			ST_F_FOUND: begin
				if (!cur_used_q)
					state_d = ST_DONE;
				else
					state_d = (idx_p1 < cnt_q) ? ST_F_NEXT : ST_F_PREV;
			end
			ST_F_NEXT: state_d = rd_used ? ST_F_PREV : ST_DN;
			ST_DN: begin
				if (j_p1 < cnt_q)
					state_d = ST_DN_WR;
				else
					state_d = phase_q ? ST_F_WR : ST_F_PREV;
			end
			ST_DN_WR:   state_d = ST_DN;
			ST_F_PREV:  state_d = (idx_q != '0) ? ST_F_PCHK : ST_F_WR;
			ST_F_PCHK:  state_d = rd_used ? ST_F_WR : ST_DN;
			ST_F_WR:    state_d = ST_DONE;
			ST_DEF_END: state_d = (sum_q != '0) ? ST_UP : ST_DONE;
			ST_DEF_INS: state_d = ST_DONE;
			ST_DONE:    state_d = out_go ? ST_IDLE : ST_DONE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// table memory control
	always_comb begin
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		case (state_q)
			ST_INIT: begin
				wr_en   = 1'b1;
				wr_data = {1'b0, cap_units};
			end
			ST_RD: rd_addr = idx_q[IW-1:0];
			ST_SCAN: begin
				// keep used entries, packed from the bottom
				if (op_q == ACT_DEFRAG && rd_used) begin
					wr_en   = 1'b1;
					wr_addr = kept_q[IW-1:0];
					wr_data = rd_q;
				end
			end
			ST_UP: rd_addr = j_m1[IW-1:0];
			ST_UP_WR: begin
				wr_en   = 1'b1;
				wr_addr = j_q[IW-1:0];
				wr_data = rd_q;
			end
			ST_INS_WR: begin
				wr_en   = 1'b1;
				wr_addr = pick_q[IW-1:0] + IW'(1);
				wr_data = {1'b0, pick_size_q - SW'(req_q)};
			end
			ST_PICK_WR: begin
				wr_en   = 1'b1;
				wr_addr = pick_q[IW-1:0];
				wr_data = {1'b1, SW'(req_q)};
			end
			ST_F_FOUND: rd_addr = idx_p1[IW-1:0];
			ST_DN:      rd_addr = j_p1[IW-1:0];
			ST_DN_WR: begin
				wr_en   = 1'b1;
				wr_addr = j_q[IW-1:0];
				wr_data = rd_q;
			end
			ST_F_PREV: rd_addr = idx_m1[IW-1:0];
			ST_F_WR: begin
				wr_en   = 1'b1;
				wr_addr = idx_q[IW-1:0];
				wr_data = {1'b0, cur_size_q};
			end
			ST_DEF_INS: begin
				wr_en   = 1'b1;
				wr_data = {1'b0, sum_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			tab_mem[wr_addr] <= wr_data;
		rd_q <= tab_mem[rd_addr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			cnt_q       <= CW'(1);
			alloc_q     <= '0;
			mem_units_q <= RESET_UNITS;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && out_go)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_INIT: begin
					cnt_q   <= CW'(1);
					alloc_q <= '0;
				end
				ST_IDLE: begin
					if (cfg_valid && cfg_ready)
						mem_units_q <= cfg_data;
				end
				ST_INS_WR:  cnt_q <= cnt_q + CW'(1);
				ST_PICK_WR: alloc_q <= alloc_q + req_q;
				ST_F_FOUND: begin
					if (cur_used_q)
						alloc_q <= alloc_q - 16'(cur_size_q);
				end
				ST_DN: begin
					if (!(j_p1 < cnt_q))
						cnt_q <= cnt_q - CW'(1);
				end
				ST_DEF_END: cnt_q <= kept_q;
				ST_DEF_INS: cnt_q <= cnt_q + CW'(1);
				default: ;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					op_q    <= action;
					req_q   <= request_size;
					tgt_q   <= free_offset;
					idx_q   <= '0;
					off_q   <= '0;
					found_q <= 1'b0;
					kept_q  <= '0;
					sum_q   <= '0;
					st_q    <= ((action inside {ACT_FIRST, ACT_BEST, ACT_WORST})
						&& request_size == '0) ? STS_ZERO : STS_OK;
				end
			end
			ST_LOOP: begin
				if (!(idx_q < cnt_q) && op_q == ACT_FREE)
					st_q <= STS_NOT_FOUND;
			end
			ST_SCAN: begin
				if (is_alloc) begin
					if (fits && better) begin
						pick_q      <= idx_q;
						pick_off_q  <= off_q;
						pick_size_q <= rd_size;
						best_q      <= diff;
						found_q     <= 1'b1;
					end
					off_q <= off_q + rd_size;
					idx_q <= idx_p1;
				end else if (op_q == ACT_FREE) begin
					if (off_match) begin
						cur_size_q <= rd_size;
						cur_used_q <= rd_used;
					end else begin
						off_q <= off_q + rd_size;
						idx_q <= idx_p1;
					end
				end else begin
					if (rd_used)
						kept_q <= kept_q + CW'(1);
					else
						sum_q <= sum_q + rd_size;
					idx_q <= idx_p1;
				end
			end
			ST_ALLOC_END: begin
				if (!found_q)
					st_q <= STS_NO_FIT;
				else if (OW'(pick_size_q) > OW'(req_q) && cnt_q == CW'(MAX_PARTS))
					st_q <= STS_FULL;
				j_q    <= cnt_q;
				stop_q <= pick_q + CW'(1);
			end
			ST_UP_WR: j_q <= j_m1;
			ST_F_NEXT: begin
				if (!rd_used) begin
					cur_size_q <= cur_size_q + rd_size;
					j_q        <= idx_p1;
					phase_q    <= 1'b0;
				end
			end
			ST_DN_WR: j_q <= j_p1;
			ST_F_PCHK: begin
				// fold into the free neighbour below, then drop this entry
				if (!rd_used) begin
					cur_size_q <= cur_size_q + rd_size;
					j_q        <= idx_q;
					idx_q      <= idx_m1;
					phase_q    <= 1'b1;
				end
			end
			ST_DEF_END: begin
				j_q    <= kept_q;
				stop_q <= '0;
			end
			ST_DONE: begin
				if (out_go) begin
					status_q          <= st_q;
					result_offset_q   <= (is_alloc && st_q == STS_OK) ? 16'(pick_off_q) : '0;
					allocated_units_q <= alloc_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign result_offset   = result_offset_q;
	assign allocated_units = allocated_units_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_PARTS))
		else $error("partition count beyond table depth");

	a_full_only_at_max: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && st_q == STS_FULL) |-> cnt_q == CW'(MAX_PARTS))
		else $error("table full reported below depth");

	a_alloc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> ((UNIT_BITS > 16) || (OW'(alloc_q) <= OW'(cap_units))))
		else $error("allocated units exceed managed size");

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("second item taken while busy");

endmodule
`default_nettype wire

>>> bench/variable_partition_allocator_top_tb.sv
// Self-checking bench for the partition allocator: directed table and corner cases, then random traffic.
`timescale 1ns / 100ps
`default_nettype none
module variable_partition_allocator_top_tb;
	import vpa_pkg::*;

	localparam int PARTS = DEF_MAX_PARTS;
	localparam int CYCLE_LIMIT = 1500000;

	typedef struct packed {
		logic [2:0]  sts;
		logic [15:0] offs;
		logic [15:0] alloc;
	} alloc_result_t;

	typedef struct packed {
		logic [2:0]  act;
		logic [15:0] req;
		logic [15:0] offs;
		logic        known;
		logic [2:0]  sts;
		logic [15:0] res_offs;
		logic [15:0] alloc;
	} dir_row_t;

	logic clk, arst_n;
	logic in_valid, in_stall;
	logic [2:0] action;
	logic [15:0] request_size, free_offset;
	logic out_valid, out_stall;
	logic [2:0] status;
	logic [15:0] result_offset, allocated_units;
	logic cfg_valid, cfg_ready;
	logic [15:0] cfg_data;

	variable_partition_allocator_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .request_size(request_size), .free_offset(free_offset),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .result_offset(result_offset), .allocated_units(allocated_units),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// predictor state
	logic [15:0] part_size [PARTS];
	logic        part_used [PARTS];
	int          part_count;
	logic [15:0] alloc_total;
	logic [15:0] mem_units;

	alloc_result_t pending_results[$];
	int  failures;
	int  cycle_count;
	bit  idle_free;
	bit  hold_long;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void table_init(logic [15:0] units);
		for (int i = 0; i < PARTS; i++) begin
			part_size[i] = '0;
			part_used[i] = 1'b0;
		end
		part_size[0] = units;
		part_count = 1;
		alloc_total = '0;
	endfunction

	function automatic void entry_remove(int at);
		for (int i = at; i + 1 < part_count; i++) begin
			part_size[i] = part_size[i+1];
			part_used[i] = part_used[i+1];
		end
		part_count--;
		part_size[part_count] = '0;
		part_used[part_count] = 1'b0;
	endfunction

	function automatic void entry_insert(int at, logic [15:0] sz, logic used);
		if (part_count >= PARTS) return;
		for (int i = part_count; i > at; i--) begin
			part_size[i] = part_size[i-1];
			part_used[i] = part_used[i-1];
		end
		part_size[at] = sz;
		part_used[at] = used;
		part_count++;
	endfunction

	function automatic alloc_result_t allocate(logic [2:0] act, logic [15:0] req);
		alloc_result_t r;
		int pick, pick_off, off, best_diff;
		bit found;
		r = '0;
		pick = 0; pick_off = 0; off = 0; best_diff = 0; found = 0;
		if (req == 0) begin
			r.sts = STS_ZERO;
			return r;
		end
		for (int i = 0; i < part_count; i++) begin
			if (!part_used[i] && part_size[i] >= req) begin
				if (act == ACT_FIRST) begin
					pick = i; pick_off = off; found = 1;
					break;
				end else if (act == ACT_BEST) begin
					if (part_size[i] == req) begin
						pick = i; pick_off = off; found = 1;
						break;
					end
					if (!found || int'(part_size[i] - req) < best_diff) begin
						pick = i; pick_off = off; found = 1;
						best_diff = int'(part_size[i] - req);
					end
				end else if (!found || part_size[i] > part_size[pick]) begin
					pick = i; pick_off = off; found = 1;
				end
			end
			off += part_size[i];
		end
		if (!found) begin
			r.sts = STS_NO_FIT;
			return r;
		end
		if (part_size[pick] > req) begin
			if (part_count >= PARTS) begin
				r.sts = STS_FULL;
				return r;
			end
			entry_insert(pick + 1, part_size[pick] - req, 1'b0);
			part_size[pick] = req;
		end
		part_used[pick] = 1'b1;
		alloc_total = alloc_total + req;
		r.sts = STS_OK;
		r.offs = pick_off[15:0];
		return r;
	endfunction

	function automatic logic [2:0] release_at(logic [15:0] target);
		int i, off;
		off = 0;
		for (i = 0; i < part_count; i++) begin
			if (off == target) break;
			off += part_size[i];
		end
		if (i >= part_count) return STS_NOT_FOUND;
		if (!part_used[i]) return STS_OK;
		alloc_total = alloc_total - part_size[i];
		part_used[i] = 1'b0;
		if (i + 1 < part_count && !part_used[i+1]) begin
			part_size[i] = part_size[i] + part_size[i+1];
			entry_remove(i + 1);
		end
		if (i > 0 && !part_used[i-1]) begin
			part_size[i-1] = part_size[i-1] + part_size[i];
			entry_remove(i);
		end
		return STS_OK;
	endfunction

	function automatic void compact();
		int kept, free_sum;
		kept = 0; free_sum = 0;
		for (int i = 0; i < part_count; i++) begin
			if (part_used[i]) begin
				part_size[kept] = part_size[i];
				part_used[kept] = 1'b1;
				kept++;
			end else begin
				free_sum += part_size[i];
			end
		end
		for (int i = kept; i < PARTS; i++) begin
			part_size[i] = '0;
			part_used[i] = 1'b0;
		end
		part_count = kept;
		if (free_sum > 0) entry_insert(0, free_sum[15:0], 1'b0);
	endfunction

	function automatic alloc_result_t predict_step(logic [2:0] act, logic [15:0] req,
			logic [15:0] offs);
		alloc_result_t r;
		r = '0;
		if (act <= ACT_WORST) r = allocate(act, req);
		else if (act == ACT_FREE) r.sts = release_at(offs);
		else if (act == ACT_DEFRAG) compact();
		if (r.sts != STS_OK) r.offs = '0;
		r.alloc = alloc_total;
		return r;
	endfunction

	// offset of a random existing partition, used or not
	function automatic logic [15:0] some_start();
		int k, off;
		k = $urandom_range(part_count > 0 ? part_count - 1 : 0);
		off = 0;
		for (int i = 0; i < k; i++) off += part_size[i];
		return off[15:0];
	endfunction

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[variable_partition_allocator_top] ERROR");
			$finish;
		end
	end

	// receiver: random stalls, one long hold-off, calm stretch
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b1;
		end else if (hold_long) begin
			out_stall <= 1'b1;
		end else begin
			out_stall <= idle_free ? 1'b0 : ($urandom_range(99) < 37);
		end
	end

	initial begin
		hold_long = 1'b0;
		@(posedge arst_n);
		repeat (300) @(posedge clk);
		hold_long <= 1'b1;
		repeat (2000) @(posedge clk);
		hold_long <= 1'b0;
	end

	always @(posedge clk) begin
		alloc_result_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{status, result_offset, allocated_units};
			if (pending_results.size() == 0) begin
				$display("%0t: result with none expected: %h", $time, got);
				failures++;
			end else begin
				want = pending_results.pop_front();
				if (got.sts !== want.sts) begin
					$display("%0t: status expected %0d actual %0d", $time, want.sts, got.sts);
					failures++;
				end
				if (got.offs !== want.offs) begin
					$display("%0t: result_offset expected %0d actual %0d", $time,
						want.offs, got.offs);
					failures++;
				end
				if (got.alloc !== want.alloc) begin
					$display("%0t: allocated_units expected %0d actual %0d", $time,
						want.alloc, got.alloc);
					failures++;
				end
			end
		end
	end

	// valid stays high after acceptance until the next item or an idle cycle drops it
	task automatic send_item(logic [2:0] act, logic [15:0] req, logic [15:0] offs,
			bit known, alloc_result_t typed);
		alloc_result_t r;
		while (!idle_free && $urandom_range(99) < 37) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		request_size <= req;
		free_offset <= offs;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		r = predict_step(act, req, offs);
		if (known && r !== typed) begin
			$display("%0t: directed row expected %h model %h", $time, typed, r);
			failures++;
		end
		pending_results.push_back(r);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4 * PARTS + 20) @(posedge clk);
	endtask

	task automatic write_units(logic [15:0] units);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= units;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		mem_units = units;
		table_init(units);
		repeat (3) @(posedge clk);
	endtask

	task automatic random_phase(int n, int big_share);
		logic [2:0] act;
		logic [15:0] req, offs;
		int pick;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				act = 3'($urandom_range(2));
			end else if (pick < 80) begin
				act = ACT_FREE;
			end else if (pick < 86) begin
				act = ACT_DEFRAG;
			end else if (pick < 90) begin
				act = 3'($urandom_range(7, 5));
			end else begin
				act = 3'($urandom_range(2));
			end
			if ($urandom_range(99) < big_share) req = 16'($urandom());
			else if ($urandom_range(19) == 0) req = 16'd0;
			else req = 16'($urandom_range(1, mem_units > 40 ? mem_units / 8 + 1 : 8));
			offs = ($urandom_range(9) == 0) ? 16'($urandom()) : some_start();
			send_item(act, req, offs, 1'b0, '0);
		end
	endtask

	dir_row_t dir_rows[$];

	initial begin
		failures = 0;
		cycle_count = 0;
		idle_free = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_FIRST;
		request_size = '0;
		free_offset = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		mem_units = RESET_UNITS;
		table_init(RESET_UNITS);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows on the reset size of 100 units
		dir_rows = '{
			'{ACT_DEFRAG, 16'd0,   16'd0,   1'b1, STS_OK,        16'd0,  16'd0},
			'{ACT_FIRST,  16'd0,   16'd0,   1'b1, STS_ZERO,      16'd0,  16'd0},
			'{ACT_FIRST,  16'hFFFF,16'd0,   1'b1, STS_NO_FIT,    16'd0,  16'd0},
			'{ACT_FIRST,  16'd10,  16'd0,   1'b1, STS_OK,        16'd0,  16'd10},
			'{ACT_BEST,   16'd20,  16'd0,   1'b1, STS_OK,        16'd10, 16'd30},
			'{ACT_WORST,  16'd5,   16'd0,   1'b1, STS_OK,        16'd30, 16'd35},
			'{ACT_FIRST,  16'd8,   16'd0,   1'b0, STS_OK,        16'd0,  16'd0},
			'{ACT_FREE,   16'd0,   16'd10,  1'b1, STS_OK,        16'd0,  16'd23},
			'{ACT_FREE,   16'd0,   16'd10,  1'b1, STS_OK,        16'd0,  16'd23},
			'{ACT_FREE,   16'd0,   16'd7,   1'b1, STS_NOT_FOUND, 16'd0,  16'd23},
			'{ACT_FREE,   16'd0,   16'hFFFF,1'b1, STS_NOT_FOUND, 16'd0,  16'd23},
			'{ACT_BEST,   16'd20,  16'd0,   1'b0, STS_OK,        16'd0,  16'd0},
			'{ACT_BEST,   16'd3,   16'd0,   1'b0, STS_OK,        16'd0,  16'd0},
			'{ACT_WORST,  16'd4,   16'd0,   1'b0, STS_OK,        16'd0,  16'd0},
			'{3'd5,       16'hFFFF,16'hFFFF,1'b0, STS_OK,        16'd0,  16'd0},
			'{3'd7,       16'd1,   16'd1,   1'b0, STS_OK,        16'd0,  16'd0},
			'{ACT_FREE,   16'd0,   16'd0,   1'b0, STS_OK,        16'd0,  16'd0},
			'{ACT_DEFRAG, 16'd0,   16'd0,   1'b0, STS_OK,        16'd0,  16'd0},
			'{ACT_WORST,  16'hFFFF,16'd0,   1'b1, STS_NO_FIT,    16'd0,  16'd40}
		};
		foreach (dir_rows[i])
			send_item(dir_rows[i].act, dir_rows[i].req, dir_rows[i].offs, dir_rows[i].known,
				'{dir_rows[i].sts, dir_rows[i].res_offs, dir_rows[i].alloc});

		// zero memory: one empty partition, defragment empties the table
		write_units(16'd0);
		send_item(ACT_FIRST, 16'd1, 16'd0, 1'b1, '{STS_NO_FIT, 16'd0, 16'd0});
		send_item(ACT_DEFRAG, 16'd0, 16'd0, 1'b1, '{STS_OK, 16'd0, 16'd0});
		send_item(ACT_FREE, 16'd0, 16'd0, 1'b1, '{STS_NOT_FOUND, 16'd0, 16'd0});

		// largest memory: fill the table with unit splits until full
		write_units(16'hFFFF);
		for (int i = 0; i < PARTS; i++) send_item(ACT_FIRST, 16'd1, 16'd0, 1'b0, '0);
		send_item(ACT_BEST, 16'd1, 16'd0, 1'b1, '{STS_FULL, 16'd0, 16'(PARTS - 1)});
		send_item(ACT_FIRST, 16'hFFFF - 16'(PARTS - 1), 16'd0, 1'b0, '0);
		random_phase(120, 30);

		write_units(16'd1);
		random_phase(60, 0);

		write_units(16'd100);
		random_phase(400, 2);

		idle_free = 1'b1;
		write_units(16'd3000);
		random_phase(200, 5);
		idle_free = 1'b0;

		write_units(16'($urandom_range(50, 65535)));
		random_phase(200, 10);

		drain();
		if (failures == 0) begin
			$display("[variable_partition_allocator_top] OK");
		end else begin
			$display("[variable_partition_allocator_top] ERROR");
		end
		$finish;
	end

endmodule
`default_nettype wire
